/* design/mec_pkg.sv */
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants of the minimum enclosing circle unit
// Widths of the fixed-point formats, controller commands and status.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int CRD_W  = 16;  // point coordinate, 4 fraction bits
  localparam int CEN_W  = 24;  // center coordinate, 8 fraction bits
  localparam int RSQ_W  = 50;  // squared radius, 16 fraction bits
  localparam int RAD_W  = 25;  // radius, 8 fraction bits
  localparam int DLT_W  = 26;  // signed point-to-center delta
  localparam int DIF_W  = 17;  // signed coordinate difference
  localparam int PRD_W  = 34;  // product of two differences
  localparam int SQS_W  = 35;  // s1, s2 and the determinant
  localparam int CRS_W  = 52;  // product of s by a difference
  localparam int NUM_W  = 53;  // nx, ny
  localparam int SNUM_W = 58;  // signed dividend 16*n + d
  localparam int QUO_W  = 57;  // dividend magnitude and quotient
  localparam int DEN_W  = 35;  // divisor 2*d
  localparam int CSUM_W = 59;  // center before saturation

  localparam logic [CEN_W-1:0] CEN_MAX = {CEN_W{1'b1}};

  typedef enum logic [4:0] {
    S_LOAD, S_INIT_RD, S_INIT_W,
    S_I_CHK, S_I_RD, S_I_CMP,
    S_J_CHK, S_J_RD, S_J_CMP, S_J_RAD, S_J_RADW,
    S_K_CHK, S_K_RD, S_K_CMP,
    S_CC_DIFF, S_CC_PROD, S_CC_CROSS, S_CC_SCALE,
    S_DIVX, S_DIVX_W, S_DIVY, S_DIVY_W,
    S_K_RAD, S_K_RADW,
    S_SQRT, S_SQRT_W, S_DONE
  } state_t;

  typedef enum logic [1:0] {SRC_MEM, SRC_PI, SRC_PJ} sq_src_t;

  typedef enum logic [2:0] {
    CEN_HOLD, CEN_MEM0, CEN_PI, CEN_MID, CEN_RAD, CEN_CCX, CEN_CCY
  } cen_op_t;

  typedef enum logic [2:0] {
    CC_IDLE, CC_DIFF, CC_PROD, CC_CROSS, CC_SCALE
  } cc_op_t;

  typedef struct packed {
    sq_src_t sq_src;
    cen_op_t cen_op;
    logic    cap_pi;
    logic    cap_pj;
    logic    cap_pk;
    cc_op_t  cc_op;
    logic    div_start;
    logic    div_sel_y;
    logic    sqrt_start;
    logic    col_set;
    logic    col_clr;
    logic    out_load;
    logic    ovf;
  } cmd_t;

  typedef struct packed {
    logic covered;
    logic det_zero;
    logic div_busy;
    logic sqrt_busy;
    logic out_busy;
  } sts_t;

endpackage

/* design/mec_ram.sv */
// ----------------------------------------------------------------------------
// mec_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/mec_div.sv */
// ----------------------------------------------------------------------------
// mec_div: restoring divider, one quotient bit per cycle
// Unsigned NW-bit dividend by DW-bit divisor; quotient and remainder.
// ----------------------------------------------------------------------------
module mec_div #(
  parameter int NW = 57,
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             take;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign take    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], take};
      rem_r <= take ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* design/mec_sqrt.sv */
// ----------------------------------------------------------------------------
// mec_sqrt: digit-by-digit integer square root, one root bit per cycle
// Floor of the square root of an IW-bit unsigned value.
// ----------------------------------------------------------------------------
module mec_sqrt #(
  parameter int IW = 50
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IW-1:0]     val,
  output logic              busy,
  output logic [IW/2-1:0]   root
);

  localparam int OW    = IW / 2;
  localparam int RW    = OW + 3;
  localparam int CNT_W = $clog2(OW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IW-1:0]    val_r;
  logic [OW-1:0]    root_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             take;

  assign rem_sh = {rem_r[RW-3:0], val_r[IW-1:IW-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(OW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= val;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[IW-3:0], 2'b00};
      root_r <= {root_r[OW-2:0], take};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

/* design/mec_ctrl.sv */
// ----------------------------------------------------------------------------
// mec_ctrl: sequencer of the minimum enclosing circle search
// Loads points, walks the three nested loops and drives the datapath.
// ----------------------------------------------------------------------------
module mec_ctrl #(
  parameter int MAX_POINTS = 128,
  parameter int AW         = 7,
  parameter int CW         = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_last,
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output logic           ram_re,
  output logic [AW-1:0]  ram_raddr,
  output mec_pkg::cmd_t  cmd,
  input  mec_pkg::sts_t  sts
);

  import mec_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          ovf_r, ovf_nxt;
  logic          full;
  logic          i_more, j_more, k_more;

  assign full   = (cnt_r == CW'(MAX_POINTS));
  assign i_more = (i_r < cnt_r);
  assign j_more = (j_r < i_r);
  assign k_more = (k_r < j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:     if (in_valid && in_last) state_nxt = S_INIT_RD;
      S_INIT_RD:  state_nxt = S_INIT_W;
      S_INIT_W:   state_nxt = S_I_CHK;
      S_I_CHK:    state_nxt = i_more ? S_I_RD : S_SQRT;
      S_I_RD:     state_nxt = S_I_CMP;
      S_I_CMP:    state_nxt = sts.covered ? S_I_CHK : S_J_CHK;
      S_J_CHK:    state_nxt = j_more ? S_J_RD : S_I_CHK;
      S_J_RD:     state_nxt = S_J_CMP;
      S_J_CMP:    state_nxt = sts.covered ? S_J_CHK : S_J_RAD;
      S_J_RAD:    state_nxt = S_J_RADW;
      S_J_RADW:   state_nxt = S_K_CHK;
      S_K_CHK:    state_nxt = k_more ? S_K_RD : S_J_CHK;
      S_K_RD:     state_nxt = S_K_CMP;
      S_K_CMP:    state_nxt = sts.covered ? S_K_CHK : S_CC_DIFF;
      S_CC_DIFF:  state_nxt = S_CC_PROD;
      S_CC_PROD:  state_nxt = S_CC_CROSS;
      S_CC_CROSS: state_nxt = sts.det_zero ? S_K_CHK : S_CC_SCALE;
      S_CC_SCALE: state_nxt = S_DIVX;
      S_DIVX:     state_nxt = S_DIVX_W;
      S_DIVX_W:   if (!sts.div_busy) state_nxt = S_DIVY;
      S_DIVY:     state_nxt = S_DIVY_W;
      S_DIVY_W:   if (!sts.div_busy) state_nxt = S_K_RAD;
      S_K_RAD:    state_nxt = S_K_RADW;
      S_K_RADW:   state_nxt = S_K_CHK;
      S_SQRT:     state_nxt = S_SQRT_W;
      S_SQRT_W:   if (!sts.sqrt_busy) state_nxt = S_DONE;
      S_DONE:     if (!sts.out_busy) state_nxt = S_LOAD;
      default:    state_nxt = S_LOAD;
    endcase
  end

  // loop counters and point count
  always_comb begin
    cnt_nxt = cnt_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    ovf_nxt = ovf_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (full) ovf_nxt = 1'b1;
          else      cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_INIT_W:   i_nxt = CW'(1);
      S_I_CMP: begin
        if (sts.covered) i_nxt = i_r + 1'b1;
        else             j_nxt = '0;
      end
      S_J_CHK:    if (!j_more) i_nxt = i_r + 1'b1;
      S_J_CMP:    if (sts.covered) j_nxt = j_r + 1'b1;
      S_J_RADW:   k_nxt = '0;
      S_K_CHK:    if (!k_more) j_nxt = j_r + 1'b1;
      S_K_CMP:    if (sts.covered) k_nxt = k_r + 1'b1;
      S_CC_CROSS: if (sts.det_zero) k_nxt = k_r + 1'b1;
      S_K_RADW:   k_nxt = k_r + 1'b1;
      S_DONE: begin
        if (!sts.out_busy) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_re         = 1'b0;
    ram_raddr      = '0;
    cmd.sq_src     = SRC_MEM;
    cmd.cen_op     = CEN_HOLD;
    cmd.cap_pi     = 1'b0;
    cmd.cap_pj     = 1'b0;
    cmd.cap_pk     = 1'b0;
    cmd.cc_op      = CC_IDLE;
    cmd.div_start  = 1'b0;
    cmd.div_sel_y  = 1'b0;
    cmd.sqrt_start = 1'b0;
    cmd.col_set    = 1'b0;
    cmd.col_clr    = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.ovf        = ovf_r;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        ram_we   = in_valid && !full;
      end
      S_INIT_RD: begin
        ram_re      = 1'b1;
        cmd.col_clr = 1'b1;
      end
      S_INIT_W:   cmd.cen_op = CEN_MEM0;
      S_I_CHK: begin
        ram_re    = i_more;
        ram_raddr = i_r[AW-1:0];
      end
      S_I_RD:     cmd.cap_pi = 1'b1;
      S_I_CMP:    if (!sts.covered) cmd.cen_op = CEN_PI;
      S_J_CHK: begin
        ram_re    = j_more;
        ram_raddr = j_r[AW-1:0];
      end
      S_J_RD:     cmd.cap_pj = 1'b1;
      S_J_CMP:    if (!sts.covered) cmd.cen_op = CEN_MID;
      S_J_RAD:    cmd.sq_src = SRC_PJ;
      S_J_RADW:   cmd.cen_op = CEN_RAD;
      S_K_CHK: begin
        ram_re    = k_more;
        ram_raddr = k_r[AW-1:0];
      end
      S_K_RD:     cmd.cap_pk = 1'b1;
      S_K_CMP:    ;
      S_CC_DIFF:  cmd.cc_op = CC_DIFF;
      S_CC_PROD:  cmd.cc_op = CC_PROD;
      S_CC_CROSS: begin
        cmd.cc_op   = CC_CROSS;
        cmd.col_set = sts.det_zero;
      end
      S_CC_SCALE: cmd.cc_op = CC_SCALE;
      S_DIVX:     cmd.div_start = 1'b1;
      S_DIVX_W:   if (!sts.div_busy) cmd.cen_op = CEN_CCX;
      S_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
      end
      S_DIVY_W:   if (!sts.div_busy) cmd.cen_op = CEN_CCY;
      S_K_RAD:    cmd.sq_src = SRC_PI;
      S_K_RADW:   cmd.cen_op = CEN_RAD;
      S_SQRT:     cmd.sqrt_start = 1'b1;
      S_SQRT_W:   ;
      S_DONE:     cmd.out_load = !sts.out_busy;
      default:    ;
    endcase
  end

endmodule

/* design/mec_dp.sv */
// ----------------------------------------------------------------------------
// mec_dp: datapath of the minimum enclosing circle search
// Containment test, circle updates, circumcenter arithmetic, result register.
// ----------------------------------------------------------------------------
module mec_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mec_pkg::cmd_t                 cmd,
  output mec_pkg::sts_t                 sts,
  input  logic [2*mec_pkg::CRD_W-1:0]   rd_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mec_pkg::CEN_W-1:0]     out_center_x,
  output logic [mec_pkg::CEN_W-1:0]     out_center_y,
  output logic [mec_pkg::RAD_W-1:0]     out_radius,
  output logic                          out_collinear_error,
  output logic                          out_overflow_error
);

  import mec_pkg::*;

  logic [CRD_W-1:0] mem_x, mem_y;
  logic [CRD_W-1:0] pix_r, piy_r, pjx_r, pjy_r, pkx_r, pky_r;
  logic [CEN_W-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [RSQ_W-1:0] rsq_r, rsq_nxt;
  logic [RSQ_W-1:0] sqx_r, sqy_r, sq_sum;

  logic [CRD_W-1:0]        sq_px, sq_py;
  logic signed [DLT_W-1:0] dx, dy;
  logic signed [2*DLT_W-1:0] dx2, dy2;

  logic signed [DIF_W-1:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [PRD_W-1:0] p_a1a1, p_b1b1, p_a2a2, p_b2b2, p_a1b2, p_a2b1;
  logic signed [SQS_W-1:0] s1_r, s2_r, d_r;
  logic signed [CRS_W-1:0] p_s1b2, p_s2b1, p_a1s2, p_a2s1;
  logic signed [NUM_W-1:0] nx_r, ny_r, nxa, nya;
  logic signed [SQS_W-1:0] dpos;
  logic                    dneg;
  logic signed [SNUM_W-1:0] numx_r, numy_r, num_sel, num_mag;
  logic [DEN_W-1:0]        den_r;
  logic                    div_neg_r;

  logic             div_busy;
  logic [QUO_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;
  logic [SNUM_W-1:0] q_up;
  logic signed [SNUM_W-1:0] q_sgn;
  logic [CRD_W-1:0] cc_base;
  logic signed [CSUM_W-1:0] csum;
  logic [CEN_W-1:0] cc_sat;
  logic [CRD_W:0]   midx, midy;

  logic             sqrt_busy;
  logic [RAD_W-1:0] root;

  logic             col_r;
  logic             out_valid_r;
  logic [CEN_W-1:0] ocx_r, ocy_r;
  logic [RAD_W-1:0] orad_r;
  logic             ocol_r, oovf_r;

  assign mem_x = rd_data[CRD_W-1:0];
  assign mem_y = rd_data[2*CRD_W-1:CRD_W];

  // point capture
  always_ff @(posedge clk) begin
    if (cmd.cap_pi) begin
      pix_r <= mem_x;
      piy_r <= mem_y;
    end
    if (cmd.cap_pj) begin
      pjx_r <= mem_x;
      pjy_r <= mem_y;
    end
    if (cmd.cap_pk) begin
      pkx_r <= mem_x;
      pky_r <= mem_y;
    end
  end

  // squared distance to the current center, one registered stage
  always_comb begin
    case (cmd.sq_src)
      SRC_PI:  begin sq_px = pix_r; sq_py = piy_r; end
      SRC_PJ:  begin sq_px = pjx_r; sq_py = pjy_r; end
      default: begin sq_px = mem_x; sq_py = mem_y; end
    endcase
  end

  assign dx  = $signed({6'b0, sq_px, 4'b0}) - $signed({2'b0, cx_r});
  assign dy  = $signed({6'b0, sq_py, 4'b0}) - $signed({2'b0, cy_r});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  always_ff @(posedge clk) begin
    sqx_r <= dx2[RSQ_W-1:0];
    sqy_r <= dy2[RSQ_W-1:0];
  end

  assign sq_sum      = sqx_r + sqy_r;
  assign sts.covered = (sq_sum <= rsq_r);

  // circumcenter: differences, squares and determinant, cross terms, scaling
  assign p_a1a1 = a1_r * a1_r;
  assign p_b1b1 = b1_r * b1_r;
  assign p_a2a2 = a2_r * a2_r;
  assign p_b2b2 = b2_r * b2_r;
  assign p_a1b2 = a1_r * b2_r;
  assign p_a2b1 = a2_r * b1_r;
  assign p_s1b2 = s1_r * b2_r;
  assign p_s2b1 = s2_r * b1_r;
  assign p_a1s2 = a1_r * s2_r;
  assign p_a2s1 = a2_r * s1_r;

  assign dneg = d_r[SQS_W-1];
  assign dpos = dneg ? -d_r : d_r;
  assign nxa  = dneg ? -nx_r : nx_r;
  assign nya  = dneg ? -ny_r : ny_r;

  always_ff @(posedge clk) begin
    case (cmd.cc_op)
      CC_DIFF: begin
        a1_r <= $signed({1'b0, pjx_r}) - $signed({1'b0, pix_r});
        b1_r <= $signed({1'b0, pjy_r}) - $signed({1'b0, piy_r});
        a2_r <= $signed({1'b0, pkx_r}) - $signed({1'b0, pix_r});
        b2_r <= $signed({1'b0, pky_r}) - $signed({1'b0, piy_r});
      end
      CC_PROD: begin
        s1_r <= {p_a1a1[PRD_W-1], p_a1a1} + {p_b1b1[PRD_W-1], p_b1b1};
        s2_r <= {p_a2a2[PRD_W-1], p_a2a2} + {p_b2b2[PRD_W-1], p_b2b2};
        d_r  <= {p_a1b2[PRD_W-1], p_a1b2} - {p_a2b1[PRD_W-1], p_a2b1};
      end
      CC_CROSS: begin
        nx_r <= {p_s1b2[CRS_W-1], p_s1b2} - {p_s2b1[CRS_W-1], p_s2b1};
        ny_r <= {p_a1s2[CRS_W-1], p_a1s2} - {p_a2s1[CRS_W-1], p_a2s1};
      end
      CC_SCALE: begin
        numx_r <= {nxa[NUM_W-1], nxa, 4'b0} + {{(SNUM_W-SQS_W){1'b0}}, dpos};
        numy_r <= {nya[NUM_W-1], nya, 4'b0} + {{(SNUM_W-SQS_W){1'b0}}, dpos};
        den_r  <= {dpos[DEN_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign sts.det_zero = (d_r == '0);

  // floor division of the signed dividend by the positive divisor
  assign num_sel = cmd.div_sel_y ? numy_r : numx_r;
  assign num_mag = num_sel[SNUM_W-1] ? -num_sel : num_sel;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg_r <= num_sel[SNUM_W-1];
    end
  end

  mec_div #(
    .NW (QUO_W),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_mag[QUO_W-1:0]),
    .den   (den_r),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign sts.div_busy = div_busy;

  assign q_up    = {1'b0, div_quo} + {{(SNUM_W-1){1'b0}}, div_neg_r && (div_rem != '0)};
  assign q_sgn   = div_neg_r ? -$signed(q_up) : $signed(q_up);
  assign cc_base = (cmd.cen_op == CEN_CCY) ? piy_r : pix_r;
  assign csum    = $signed({{(CSUM_W-CRD_W-4){1'b0}}, cc_base, 4'b0})
                 + $signed({q_sgn[SNUM_W-1], q_sgn});

  always_comb begin
    if (csum[CSUM_W-1])                    cc_sat = '0;
    else if (csum[CSUM_W-2:CEN_W] != '0)   cc_sat = CEN_MAX;
    else                                   cc_sat = csum[CEN_W-1:0];
  end

  // circle update
  assign midx = {1'b0, pix_r} + {1'b0, pjx_r};
  assign midy = {1'b0, piy_r} + {1'b0, pjy_r};

  always_comb begin
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    rsq_nxt = rsq_r;
    case (cmd.cen_op)
      CEN_MEM0: begin
        cx_nxt  = {4'b0, mem_x, 4'b0};
        cy_nxt  = {4'b0, mem_y, 4'b0};
        rsq_nxt = '0;
      end
      CEN_PI: begin
        cx_nxt  = {4'b0, pix_r, 4'b0};
        cy_nxt  = {4'b0, piy_r, 4'b0};
        rsq_nxt = '0;
      end
      CEN_MID: begin
        cx_nxt = {4'b0, midx, 3'b0};
        cy_nxt = {4'b0, midy, 3'b0};
      end
      CEN_RAD: rsq_nxt = sq_sum;
      CEN_CCX: cx_nxt  = cc_sat;
      CEN_CCY: cy_nxt  = cc_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rsq_r <= '0;
    end else begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      rsq_r <= rsq_nxt;
    end
  end

  mec_sqrt #(
    .IW (RSQ_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .val   (rsq_r),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign sts.sqrt_busy = sqrt_busy;

  // collinear flag and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.col_clr)      col_r <= 1'b0;
      else if (cmd.col_set) col_r <= 1'b1;
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ocx_r  <= cx_r;
      ocy_r  <= cy_r;
      orad_r <= root;
      ocol_r <= col_r;
      oovf_r <= cmd.ovf;
    end
  end

  assign sts.out_busy        = out_valid_r && !out_ready;
  assign out_valid           = out_valid_r;
  assign out_center_x        = ocx_r;
  assign out_center_y        = ocy_r;
  assign out_radius          = orad_r;
  assign out_collinear_error = ocol_r;
  assign out_overflow_error  = oovf_r;

endmodule

/* design/min_enclosing_circle_unit.sv */
// ----------------------------------------------------------------------------
// min_enclosing_circle_unit: minimum enclosing circle of a point set
// Stores points, then runs the incremental three-level search in arrival
// order and returns center, radius and error flags.
// ----------------------------------------------------------------------------
//
//  channel | ports                                              | beat
//  --------+----------------------------------------------------+---------------
//  in      | in_valid/in_ready, in_point_x/y, in_last_point     | one point
//  out     | out_valid/out_ready, out_center_x/y, out_radius,   | one circle
//          | out_collinear_error, out_overflow_error            |
//
//  Points load one per cycle into the point RAM. The beat marked last starts
//  the search and holds in_ready low until the result is registered.
//  Each point test is a RAM read, a squared distance and a compare; a
//  two-point circle adds a radius update, and a three-point circle is
//  dominated by two 57-step divisions in the shared divider. The radius
//  square root is taken after the search. Worst case grows with the cube of the
//  point count. Reset is synchronous; no clearing pass runs. A waiting
//  result does not block loading of the next set, but the next search
//  holds before its result register until the waiting beat is taken.
//
module min_enclosing_circle_unit #(
  parameter int MAX_POINTS = 128,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mec_pkg::CRD_W-1:0]   in_point_x,
  input  logic [mec_pkg::CRD_W-1:0]   in_point_y,
  input  logic                        in_last_point,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mec_pkg::CEN_W-1:0]   out_center_x,
  output logic [mec_pkg::CEN_W-1:0]   out_center_y,
  output logic [mec_pkg::RAD_W-1:0]   out_radius,
  output logic                        out_collinear_error,
  output logic                        out_overflow_error
);

  import mec_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // keep only the low COORD_BITS of each coordinate
  localparam logic [CRD_W-1:0] CoordMask = (COORD_BITS >= CRD_W) ? {CRD_W{1'b1}}
                                         : CRD_W'((64'd1 << COORD_BITS) - 64'd1);

  cmd_t                cmd;
  sts_t                sts;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [2*CRD_W-1:0]  ram_wdata, ram_rdata;

  assign ram_wdata = {in_point_y & CoordMask, in_point_x & CoordMask};

  mec_ram #(
    .WIDTH (2 * CRD_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mec_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last_point),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .cmd       (cmd),
    .sts       (sts)
  );

  mec_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .rd_data             (ram_rdata),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_center_x        (out_center_x),
    .out_center_y        (out_center_y),
    .out_radius          (out_radius),
    .out_collinear_error (out_collinear_error),
    .out_overflow_error  (out_overflow_error)
  );

endmodule
